[sv/chrt_pkg.sv]
// ----------------------------------------------------------------------------
// chrt_pkg
// Types, command codes and status codes of the hash ring table.
// ----------------------------------------------------------------------------
package chrt_pkg;

    localparam int RING_DEPTH_DEF = 256;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] ring_position;
        logic [31:0] server_address;
    } chrt_in_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] owner_address;
        logic [1:0]  status;
        logic [8:0]  entry_count;
    } chrt_out_t;

    typedef struct packed {
        logic [31:0] position;
        logic [31:0] owner;
    } chrt_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_REM_RD,
        ST_REM_CHK,
        ST_LK_RD,
        ST_LK_CHK,
        ST_RESP
    } chrt_state_t;

endpackage

[sv/chrt_ram.sv]
// ----------------------------------------------------------------------------
// chrt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module chrt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/consistent_hash_ring_table_core.sv]
// ----------------------------------------------------------------------------
// consistent_hash_ring_table_core
// Sorted table of ring positions with owning server addresses.
//
// One command item enters on the s_ channel (s_valid/s_ready/s_data) and
// exactly one result item leaves on the m_ channel (m_valid/m_ready/m_data).
// Insert places an entry in ascending position order after any equal ones,
// remove drops every entry of one server, lookup returns the owner of the
// first entry above the given position and wraps to the first entry.
// The table sits in one RAM with a registered read port; every entry visited
// passes through a read state and a compare state. Insert walks down from
// the end and moves entries up to the insert point, remove walks the whole
// table, lookup walks up to the hit; a full table, an empty ring and unused
// codes go straight to the result state.
// One item at a time: s_ready is high only while no command is in work.
// The result waits in an output register; a new item is accepted while it
// waits, and a stalled receiver only holds the next result back.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module consistent_hash_ring_table_core
    import chrt_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  chrt_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output chrt_out_t m_data
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int EW = $bits(chrt_entry_t);

    chrt_state_t state_reg, state_next;
    chrt_in_t    req_reg, req_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wix_reg, wix_next;
    logic          res_hit_reg, res_hit_next;
    logic [31:0]   res_owner_reg, res_owner_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic          m_valid_reg, m_valid_next;
    chrt_out_t     m_data_reg, m_data_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    chrt_entry_t   wr_data;
    logic [AW-1:0] rd_addr;
    chrt_entry_t   rd_data;
    logic [EW-1:0] rd_bits;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] idx_inc;
    logic [CW+8:0] cnt_ext;
    chrt_entry_t   new_entry;

    chrt_ram #(
        .WIDTH(EW),
        .DEPTH(RING_DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_bits)
    );

    assign rd_data   = chrt_entry_t'(rd_bits);
    assign idx_dec   = idx_reg - 1'b1;
    assign idx_inc   = idx_reg + 1'b1;
    assign cnt_ext   = (CW + 9)'(count_reg);
    assign new_entry = '{position: req_reg.ring_position, owner: req_reg.server_address};

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            wix_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            wix_reg     <= wix_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg        <= req_next;
        res_hit_reg    <= res_hit_next;
        res_owner_reg  <= res_owner_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        wix_next        = wix_reg;
        res_hit_next    = res_hit_reg;
        res_owner_next  = res_owner_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_data         = new_entry;
        rd_addr         = idx_reg[AW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next        = s_data;
                    res_hit_next    = 1'b0;
                    res_owner_next  = '0;
                    res_status_next = STAT_OK;
                    idx_next        = '0;
                    wix_next        = '0;
                    state_next      = ST_RESP;
                    unique case (s_data.cmd)
                        CMD_INSERT: begin
                            if (count_reg >= CW'(RING_DEPTH)) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                idx_next   = count_reg;
                                state_next = ST_INS_RD;
                            end
                        end
                        CMD_REMOVE: begin
                            state_next = ST_REM_RD;
                        end
                        CMD_LOOKUP: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                            end else begin
                                state_next = ST_LK_RD;
                            end
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_INS_RD: begin
                if (idx_reg == '0) begin
                    wr_en        = 1'b1;
                    wr_addr      = '0;
                    wr_data      = new_entry;
                    count_next   = count_reg + 1'b1;
                    res_hit_next = 1'b1;
                    state_next   = ST_RESP;
                end else begin
                    rd_addr    = idx_dec[AW-1:0];
                    state_next = ST_INS_CHK;
                end
            end
            ST_INS_CHK: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                if (rd_data.position > req_reg.ring_position) begin
                    wr_data    = rd_data;
                    idx_next   = idx_dec;
                    state_next = ST_INS_RD;
                end else begin
                    wr_data      = new_entry;
                    count_next   = count_reg + 1'b1;
                    res_hit_next = 1'b1;
                    state_next   = ST_RESP;
                end
            end
            ST_REM_RD: begin
                if (idx_reg == count_reg) begin
                    if (wix_reg == count_reg) begin
                        res_status_next = STAT_NOT_FOUND;
                    end else begin
                        count_next   = wix_reg;
                        res_hit_next = 1'b1;
                    end
                    state_next = ST_RESP;
                end else begin
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = ST_REM_CHK;
                end
            end
            ST_REM_CHK: begin
                if (rd_data.owner != req_reg.server_address) begin
                    wr_en    = 1'b1;
                    wr_addr  = wix_reg[AW-1:0];
                    wr_data  = rd_data;
                    wix_next = wix_reg + 1'b1;
                end
                idx_next   = idx_inc;
                state_next = ST_REM_RD;
            end
            ST_LK_RD: begin
                // past the last entry the answer wraps to the first
                if (idx_reg == count_reg) begin
                    rd_addr = '0;
                end else begin
                    rd_addr = idx_reg[AW-1:0];
                end
                state_next = ST_LK_CHK;
            end
            ST_LK_CHK: begin
                if (idx_reg == count_reg ||
                    rd_data.position > req_reg.ring_position) begin
                    res_hit_next   = 1'b1;
                    res_owner_next = rd_data.owner;
                    state_next     = ST_RESP;
                end else begin
                    idx_next   = idx_inc;
                    state_next = ST_LK_RD;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.hit           = res_hit_reg;
                    m_data_next.owner_address = res_owner_reg;
                    m_data_next.status        = res_status_reg;
                    m_data_next.entry_count   = cnt_ext[8:0];
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[test/tb_consistent_hash_ring_table_core.sv]
// ----------------------------------------------------------------------------
// tb_consistent_hash_ring_table_core
// Self-checking testbench for the hash ring table core.
//
// Command items go in on the s_ channel, and each result item is compared
// field by field with a prediction. The prediction keeps its own sorted
// table, which is updated whenever the block accepts a command. The run
// covers empty, wrapping and equal-position corners first. It then mixes
// random inserts, lookups and removes over a small pool of servers, fills
// the table until inserts are refused, and stalls the result side long
// enough to back up the input.
// ----------------------------------------------------------------------------
module tb_consistent_hash_ring_table_core;
    import chrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RING_DEPTH  = RING_DEPTH_DEF;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          POOL_SIZE   = 16;
    localparam int          RECENT_MAX  = 64;
    localparam int          TAIL_CYCLES = 600;
    localparam longint      CYCLE_LIMIT = 4_000_000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    chrt_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    chrt_out_t m_data;

    logic [31:0] ring_pos   [RING_DEPTH];
    logic [31:0] ring_owner [RING_DEPTH];
    int          ring_count;
    chrt_out_t   expected_replies [$];

    logic [31:0] server_pool [POOL_SIZE];
    logic [31:0] recent_positions [$];
    logic        idle_on;
    int          hold_request;
    int          error_count;
    longint      cycle_count;

    consistent_hash_ring_table_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic int first_above(input logic [31:0] pos);
        int i;
        for (i = 0; i < ring_count; i++) begin
            if (ring_pos[i] > pos) begin
                return i;
            end
        end
        return ring_count;
    endfunction

    task automatic apply_ring_command(input chrt_in_t item);
        chrt_out_t res;
        int        i;
        int        j;
        int        k;
        res = '0;
        case (item.cmd)
            CMD_INSERT: begin
                if (ring_count >= RING_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    k = first_above(item.ring_position);
                    for (i = ring_count; i > k; i--) begin
                        ring_pos[i]   = ring_pos[i-1];
                        ring_owner[i] = ring_owner[i-1];
                    end
                    ring_pos[k]   = item.ring_position;
                    ring_owner[k] = item.server_address;
                    ring_count++;
                    res.hit    = 1'b1;
                    res.status = STAT_OK;
                end
            end
            CMD_REMOVE: begin
                j = 0;
                for (i = 0; i < ring_count; i++) begin
                    if (ring_owner[i] != item.server_address) begin
                        ring_pos[j]   = ring_pos[i];
                        ring_owner[j] = ring_owner[i];
                        j++;
                    end
                end
                if (j == ring_count) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    ring_count = j;
                    res.hit    = 1'b1;
                    res.status = STAT_OK;
                end
            end
            CMD_LOOKUP: begin
                if (ring_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    k = first_above(item.ring_position);
                    if (k >= ring_count) begin
                        k = 0;
                    end
                    res.hit           = 1'b1;
                    res.owner_address = ring_owner[k];
                    res.status        = STAT_OK;
                end
            end
            default: begin
                res.status = STAT_OK;
            end
        endcase
        res.entry_count = ring_count[8:0];
        expected_replies.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    task automatic check_reply(input chrt_out_t got);
        chrt_out_t want;
        if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("result item with none pending: %h", got));
            return;
        end
        want = expected_replies.pop_front();
        check_field("hit", 32'(got.hit), 32'(want.hit));
        check_field("owner_address", got.owner_address, want.owner_address);
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
    endtask

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                check_reply(m_data);
            end
            if (s_valid === 1'b1 && s_ready === 1'b1) begin
                apply_ring_command(s_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = idle_on ? $urandom_range(0, 18) : 0;
            if (hold_request > 0) begin
                gap          = hold_request;
                hold_request = 0;
            end
            if (gap > 0) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk) m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
        end
    end

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------
    task automatic send_command(input logic [1:0] op, input logic [31:0] pos,
                                input logic [31:0] addr);
        chrt_in_t item;
        int       gap;
        item.cmd            = op;
        item.ring_position  = pos;
        item.server_address = addr;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic wait_idle();
        @(negedge aclk) s_valid <= 1'b0;
        while (expected_replies.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] pick_position();
        int          roll;
        logic [31:0] near;
        roll = $urandom_range(0, 99);
        if (recent_positions.size() > 0) begin
            near = recent_positions[$urandom_range(0, recent_positions.size() - 1)];
        end else begin
            near = $urandom;
        end
        if (roll < 55) return $urandom;
        if (roll < 75) return near;
        if (roll < 82) return near + 32'd1;
        if (roll < 89) return near - 32'd1;
        if (roll < 94) return 32'h0;
        return 32'hFFFF_FFFF;
    endfunction

    task automatic send_random_command();
        int          roll;
        logic [1:0]  op;
        logic [31:0] pos;
        logic [31:0] addr;
        roll = $urandom_range(0, 99);
        pos  = pick_position();
        addr = server_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 45) begin
            op = CMD_INSERT;
        end else if (roll < 85) begin
            op = CMD_LOOKUP;
        end else if (roll < 95) begin
            op = CMD_REMOVE;
            if ($urandom_range(0, 5) == 0) begin
                addr = $urandom;
            end
        end else begin
            op   = CMD_UNUSED;
            addr = $urandom;
        end
        if (op == CMD_INSERT) begin
            recent_positions.push_back(pos);
            if (recent_positions.size() > RECENT_MAX) begin
                void'(recent_positions.pop_front());
            end
        end
        send_command(op, pos, addr);
    endtask

    task automatic drain_ring();
        int i;
        for (i = 0; i < POOL_SIZE; i++) begin
            send_command(CMD_REMOVE, $urandom, server_pool[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_corners();
        idle_on = 1'b1;
        send_command(CMD_LOOKUP, 32'h0000_1234, 32'h0);
        send_command(CMD_REMOVE, 32'h0, server_pool[2]);
        send_command(CMD_UNUSED, 32'h0, 32'h0);
        send_command(CMD_INSERT, 32'h0000_0000, server_pool[0]);
        send_command(CMD_INSERT, 32'hFFFF_FFFF, server_pool[1]);
        send_command(CMD_INSERT, 32'h8000_0000, server_pool[2]);
        send_command(CMD_INSERT, 32'h8000_0000, server_pool[3]);
        send_command(CMD_INSERT, 32'h0000_0000, server_pool[1]);
        send_command(CMD_LOOKUP, 32'h0000_0000, 32'h0);
        send_command(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0);
        send_command(CMD_LOOKUP, 32'h8000_0000, 32'h0);
        send_command(CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0);
        send_command(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_command(CMD_REMOVE, 32'h0, server_pool[2]);
        send_command(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0);
        send_command(CMD_REMOVE, 32'h0, 32'h1234_5678);
        send_command(CMD_REMOVE, 32'h0, server_pool[0]);
        send_command(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_command(CMD_REMOVE, 32'h0, server_pool[1]);
        send_command(CMD_REMOVE, 32'h0, server_pool[3]);
        send_command(CMD_LOOKUP, 32'h0000_0000, 32'h0);
        send_command(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_ring_churn(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            // every third stretch runs with no gaps on either side
            idle_on = ((i / 150) % 3) != 2;
            send_random_command();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_full_table();
        int fill;
        int i;
        idle_on = 1'b1;
        drain_ring();
        wait_idle();
        fill = RING_DEPTH - ring_count;
        for (i = 0; i < fill + 3; i++) begin
            send_command(CMD_INSERT, pick_position(),
                         server_pool[$urandom_range(0, POOL_SIZE - 1)]);
        end
        send_command(CMD_LOOKUP, 32'h0000_0000, 32'h0);
        send_command(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        for (i = 0; i < 6; i++) begin
            send_command(CMD_LOOKUP, pick_position(), 32'h0);
        end
        send_command(CMD_REMOVE, 32'h0, server_pool[$urandom_range(0, POOL_SIZE - 1)]);
        send_command(CMD_INSERT, pick_position(), server_pool[0]);
        drain_ring();
    endtask

    task automatic test_output_backpressure();
        int i;
        idle_on      = 1'b0;
        hold_request = 400;
        for (i = 0; i < 16; i++) begin
            send_random_command();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        int i;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        idle_on      = 1'b1;
        hold_request = 0;
        error_count  = 0;
        cycle_count  = 0;
        ring_count   = 0;
        server_pool[0] = 32'h0000_0000;
        server_pool[1] = 32'hFFFF_FFFF;
        server_pool[2] = 32'h5A5A_0001;
        server_pool[3] = 32'hA5A5_FFFE;
        for (i = 4; i < POOL_SIZE; i++) begin
            server_pool[i] = $urandom;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_directed_corners();
        test_ring_churn(900);
        test_full_table();
        test_output_backpressure();
        test_ring_churn(300);

        @(negedge aclk) s_valid <= 1'b0;
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
sv/chrt_pkg.sv
sv/chrt_ram.sv
sv/consistent_hash_ring_table_core.sv
test/tb_consistent_hash_ring_table_core.sv
